### hw/rtl/gjdu_pkg.sv
// types, constants and tables shared by the date unit modules
package gjdu_pkg;

	// input transaction as carried in s_tdata, first field in the low bits
	typedef struct packed {
		logic [2:0]         pad;
		logic [13:0]        other_year;
		logic [5:0]         other_day;
		logic [3:0]         other_month;
		logic signed [20:0] day_offset;
		logic [13:0]        date_year;
		logic [5:0]         date_day;
		logic [3:0]         date_month;
	} in_item_t;

	// fields that ride along with the shifted day number
	typedef struct packed {
		logic        dflt;
		logic [22:0] jo;
		logic [13:0] by;
		logic [4:0]  bd;
		logic [3:0]  bm;
	} carry_t;

	typedef struct packed {
		carry_t      c;
		logic [23:0] jd;
	} q_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic               out_of_range;
		logic               was_defaulted;
		logic signed [22:0] days_between;
		logic [2:0]         weekday;
		logic [8:0]         day_of_year;
		logic [22:0]        julian_day;
		logic [13:0]        new_year;
		logic [4:0]         new_day;
		logic [3:0]         new_month;
	} res_t;

	localparam logic [3:0]  DEF_MONTH = 4'd5;
	localparam logic [4:0]  DEF_DAY   = 5'd11;
	localparam logic [13:0] DEF_YEAR  = 14'd1959;
	localparam logic [3:0]  MONTH_MAX = 4'd12;
	localparam logic [5:0]  DAY_MAX   = 6'd31;
	localparam logic [16:0] YEAR_MAX  = 17'd9999;

	localparam logic [23:0] JDN_BIAS = 24'd32075;
	localparam logic [23:0] FJ_BIAS  = 24'd68569;
	localparam logic [16:0] CENT_BIAS = 17'd4900;

	// reciprocal constants: floor(x / c) = (x * ceil(2^s / c)) >> s
	localparam int          Q100_S = 22;
	localparam logic [15:0] Q100_M = 16'(((64'd1 << 22) + 64'd99) / 64'd100);

	localparam int          QN_S = 44;
	localparam logic [28:0] QN_K = 29'(64'd4 * (((64'd1 << 44) + 64'd146096) / 64'd146097));

	localparam int          QI_S = 49;
	localparam logic [40:0] QI_K =
		41'(64'd4000 * (((64'd1 << 49) + 64'd1461000) / 64'd1461001));

	localparam int          QJ_S = 27;
	localparam logic [22:0] QJ_K = 23'(64'd80 * (((64'd1 << 27) + 64'd2446) / 64'd2447));

	localparam int          Q7_S = 26;
	localparam logic [23:0] Q7_M = 24'(((64'd1 << 26) + 64'd6) / 64'd7);

	// floor(367 * (m - 2 - 12a) / 12) for months 0..12
	function automatic logic [8:0] month_term(input logic [3:0] m);
		logic [8:0] t;
		case (m)
			4'd0:    t = 9'd305;
			4'd1:    t = 9'd336;
			4'd2:    t = 9'd367;
			4'd3:    t = 9'd30;
			4'd4:    t = 9'd61;
			4'd5:    t = 9'd91;
			4'd6:    t = 9'd122;
			4'd7:    t = 9'd152;
			4'd8:    t = 9'd183;
			4'd9:    t = 9'd214;
			4'd10:   t = 9'd244;
			4'd11:   t = 9'd275;
			4'd12:   t = 9'd305;
			default: t = 9'd0;
		endcase
		return t;
	endfunction

	// floor(2447 * j / 80)
	function automatic logic [8:0] month_days(input logic [4:0] j);
		logic [8:0] t;
		case (j)
			5'd0:    t = 9'd0;
			5'd1:    t = 9'd30;
			5'd2:    t = 9'd61;
			5'd3:    t = 9'd91;
			5'd4:    t = 9'd122;
			5'd5:    t = 9'd152;
			5'd6:    t = 9'd183;
			5'd7:    t = 9'd214;
			5'd8:    t = 9'd244;
			5'd9:    t = 9'd275;
			5'd10:   t = 9'd305;
			5'd11:   t = 9'd336;
			5'd12:   t = 9'd367;
			5'd13:   t = 9'd397;
			5'd14:   t = 9'd428;
			5'd15:   t = 9'd458;
			default: t = 9'd0;
		endcase
		return t;
	endfunction

endpackage

### hw/rtl/gjdu_jdn.sv
// two-stage date to julian day number converter
module gjdu_jdn (
	input  logic        clk,
	input  logic        en,
	input  logic [3:0]  m,
	input  logic [4:0]  d,
	input  logic [13:0] y,
	output logic [22:0] jd
);
	logic        lo_m;
	logic [14:0] ya;
	logic [14:0] yb;
	logic [22:0] t1_s1;
	logic [29:0] pq_s1;
	logic [8:0]  dt_s1;
	logic [7:0]  q;
	logic [7:0]  t3;

	// january and february count in the previous year
	assign lo_m = (m < 4'd3);
	assign ya = 15'(y) + (lo_m ? 15'd4799 : 15'd4800);
	assign yb = 15'(y) + (lo_m ? 15'd4899 : 15'd4900);

	always_ff @(posedge clk) begin
		if (en) begin
			t1_s1 <= 23'(24'(ya) * 24'd365 + 24'(ya >> 2));
			pq_s1 <= 30'(31'(yb) * 31'(gjdu_pkg::Q100_M));
			dt_s1 <= 9'(d) + gjdu_pkg::month_term(m);
		end
	end

	assign q  = pq_s1[gjdu_pkg::Q100_S +: 8];
	assign t3 = 8'((10'(q) * 10'd3) >> 2);

	always_ff @(posedge clk) begin
		if (en) begin
			jd <= 23'(24'(t1_s1) + 24'(dt_s1) - 24'(t3) - gjdu_pkg::JDN_BIAS);
		end
	end
endmodule

### hw/rtl/gjdu_front.sv
// front end: default bad dates, convert both dates, apply the offset
module gjdu_front (
	input  logic               clk,
	input  logic               arst_n,
	input  gjdu_pkg::in_item_t item,
	input  logic               in_valid,
	output logic               in_ready,
	input  gjdu_pkg::q_stat_t  q_stat,
	output logic               push,
	output gjdu_pkg::q_item_t  push_data
);
	logic               bad_b, bad_o, en;
	logic [3:0]         bm, om;
	logic [4:0]         bd, od;
	logic [13:0]        by, oy;
	logic               v_s1, v_s2;
	logic [3:0]         bm_s1, bm_s2;
	logic [4:0]         bd_s1, bd_s2;
	logic [13:0]        by_s1, by_s2;
	logic signed [20:0] off_s1, off_s2;
	logic               dflt_s1, dflt_s2;
	logic [22:0]        jb, jo;
	logic signed [24:0] shifted;

	assign bad_b = (item.date_month > gjdu_pkg::MONTH_MAX) || (item.date_day > gjdu_pkg::DAY_MAX);
	assign bad_o = (item.other_month > gjdu_pkg::MONTH_MAX) ||
		(item.other_day > gjdu_pkg::DAY_MAX);
	assign bm = bad_b ? gjdu_pkg::DEF_MONTH : item.date_month;
	assign bd = bad_b ? gjdu_pkg::DEF_DAY   : item.date_day[4:0];
	assign by = bad_b ? gjdu_pkg::DEF_YEAR  : item.date_year;
	assign om = bad_o ? gjdu_pkg::DEF_MONTH : item.other_month;
	assign od = bad_o ? gjdu_pkg::DEF_DAY   : item.other_day[4:0];
	assign oy = bad_o ? gjdu_pkg::DEF_YEAR  : item.other_year;

	// stall only while the last stage waits on a full queue
	assign en       = !(v_s2 && q_stat.full);
	assign in_ready = en;
	assign push     = v_s2 && !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bm_s1   <= bm;
			bd_s1   <= bd;
			by_s1   <= by;
			off_s1  <= item.day_offset;
			dflt_s1 <= bad_b || bad_o;
			bm_s2   <= bm_s1;
			bd_s2   <= bd_s1;
			by_s2   <= by_s1;
			off_s2  <= off_s1;
			dflt_s2 <= dflt_s1;
		end
	end

	gjdu_jdn u_jdn_base (.clk(clk), .en(en), .m(bm), .d(bd), .y(by), .jd(jb));
	gjdu_jdn u_jdn_other (.clk(clk), .en(en), .m(om), .d(od), .y(oy), .jd(jo));

	assign shifted = $signed({2'b00, jb}) + 25'(off_s2);

	always_comb begin
		push_data.jd     = shifted[23:0];
		push_data.c.bm   = bm_s2;
		push_data.c.bd   = bd_s2;
		push_data.c.by   = by_s2;
		push_data.c.jo   = jo;
		push_data.c.dflt = dflt_s2;
	end
endmodule

### hw/rtl/gjdu_queue.sv
// four-entry queue between front and back end
module gjdu_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gjdu_pkg::q_item_t push_data,
	input  logic              pop,
	output gjdu_pkg::q_item_t head,
	output gjdu_pkg::q_stat_t stat
);
	gjdu_pkg::q_item_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 2'd0;
			rp_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop)  rp_q <= rp_q + 2'd1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 3'd1;
				2'b01:   cnt_q <= cnt_q - 3'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	assign head       = mem_q[rp_q];
	assign stat.full  = (cnt_q == 3'd4);
	assign stat.empty = (cnt_q == 3'd0);
endmodule

### hw/rtl/gjdu_back.sv
// back end: day number to date, range check, reconversion and result fields
module gjdu_back (
	input  logic              clk,
	input  logic              arst_n,
	input  gjdu_pkg::q_item_t head,
	input  gjdu_pkg::q_stat_t q_stat,
	output logic              pop,
	output gjdu_pkg::res_t    res,
	output logic              res_valid,
	input  logic              res_ready
);
	logic                en;
	logic [10:1]         vld_q;
	gjdu_pkg::carry_t    c_s1, c_s2, c_s3, c_s4, c_s5, c_s6;
	logic [23:0]         l0, l0_s1;
	logic [52:0]         pn_s1;
	logic [7:0]          n, n_s2, n_s3, n_s4, n_s5;
	logic [23:0]         tn;
	logic [15:0]         l1_s2, l1_s3;
	logic [56:0]         pi_s3;
	logic [6:0]          i, i_s4, i_s5;
	logic [17:0]         ti;
	logic [8:0]          l2_s4, l2_s5;
	logic [31:0]         pj_s5;
	logic [4:0]          j;
	logic                l3;
	logic [3:0]          nm_s6;
	logic [4:0]          nd_s6;
	logic [16:0]         ny_s6;
	logic                oor;
	logic [3:0]          sm;
	logic [4:0]          sd;
	logic [13:0]         sy;
	logic [3:0]          m_s7, m_s8, m_s9;
	logic [4:0]          d_s7, d_s8, d_s9;
	logic [13:0]         y_s7, y_s8, y_s9;
	logic                oor_s7, oor_s8, oor_s9;
	logic                dflt_s7, dflt_s8, dflt_s9;
	logic [22:0]         jo_s7, jo_s8;
	logic [22:0]         ja, jb;
	logic signed [23:0]  dd;
	logic [22:0]         jnew_s9;
	logic [46:0]         pw_s9;
	logic [8:0]          doy_s9;
	logic [22:0]         diff_s9;
	logic [20:0]         wq;

	assign en        = !(vld_q[10] && !res_ready);
	assign pop       = en && !q_stat.empty;
	assign res_valid = vld_q[10];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[9:1], pop};
		end
	end

	// day number to calendar date
	assign l0 = head.jd + gjdu_pkg::FJ_BIAS;
	assign n  = pn_s1[gjdu_pkg::QN_S +: 8];
	assign tn = 24'((26'(n) * 26'd146097 + 26'd3) >> 2);
	assign i  = pi_s3[gjdu_pkg::QI_S +: 7];
	assign ti = 18'((18'(i) * 18'd1461) >> 2);
	assign j  = pj_s5[gjdu_pkg::QJ_S +: 5];
	assign l3 = (j >= 5'd11);

	// out of range keeps the defaulted base date
	assign oor = $signed(ny_s6) < 0 || $signed(ny_s6) > $signed(gjdu_pkg::YEAR_MAX);
	assign sm  = oor ? c_s6.bm : nm_s6;
	assign sd  = oor ? c_s6.bd : nd_s6;
	assign sy  = oor ? c_s6.by : ny_s6[13:0];

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1  <= head.c;
			l0_s1 <= l0;
			pn_s1 <= 53'(l0) * 53'(gjdu_pkg::QN_K);

			c_s2  <= c_s1;
			n_s2  <= n;
			l1_s2 <= 16'(l0_s1 - tn);

			c_s3  <= c_s2;
			n_s3  <= n_s2;
			l1_s3 <= l1_s2;
			pi_s3 <= 57'(l1_s2 + 16'd1) * 57'(gjdu_pkg::QI_K);

			c_s4  <= c_s3;
			n_s4  <= n_s3;
			i_s4  <= i;
			l2_s4 <= 9'(l1_s3 - 16'(ti) + 16'd31);

			c_s5  <= c_s4;
			n_s5  <= n_s4;
			i_s5  <= i_s4;
			l2_s5 <= l2_s4;
			pj_s5 <= 32'(l2_s4) * 32'(gjdu_pkg::QJ_K);

			c_s6  <= c_s5;
			nd_s6 <= 5'(l2_s5 - gjdu_pkg::month_days(j));
			nm_s6 <= 4'(j + 5'd2 - (l3 ? 5'd12 : 5'd0));
			ny_s6 <= 17'(n_s5) * 17'd100 + 17'(i_s5) + 17'(l3) - gjdu_pkg::CENT_BIAS;

			m_s7    <= sm;
			d_s7    <= sd;
			y_s7    <= sy;
			oor_s7  <= oor;
			jo_s7   <= c_s6.jo;
			dflt_s7 <= c_s6.dflt;

			m_s8    <= m_s7;
			d_s8    <= d_s7;
			y_s8    <= y_s7;
			oor_s8  <= oor_s7;
			jo_s8   <= jo_s7;
			dflt_s8 <= dflt_s7;
		end
	end

	// day number of the result date and of day zero of its year
	gjdu_jdn u_jdn_date (.clk(clk), .en(en), .m(sm), .d(sd), .y(sy), .jd(ja));
	gjdu_jdn u_jdn_year (.clk(clk), .en(en), .m(4'd1), .d(5'd0), .y(sy), .jd(jb));

	assign dd = $signed({1'b0, jo_s8}) - $signed({1'b0, ja});
	assign wq = pw_s9[gjdu_pkg::Q7_S +: 21];

	always_ff @(posedge clk) begin
		if (en) begin
			jnew_s9 <= ja;
			pw_s9   <= 47'(ja) * 47'(gjdu_pkg::Q7_M);
			doy_s9  <= 9'(ja - jb);
			if (dd[23] != dd[22]) begin
				diff_s9 <= dd[23] ? 23'h400000 : 23'h3fffff;
			end else begin
				diff_s9 <= dd[22:0];
			end
			m_s9    <= m_s8;
			d_s9    <= d_s8;
			y_s9    <= y_s8;
			oor_s9  <= oor_s8;
			dflt_s9 <= dflt_s8;

			res.new_month     <= m_s9;
			res.new_day       <= d_s9;
			res.new_year      <= y_s9;
			res.julian_day    <= jnew_s9;
			res.day_of_year   <= doy_s9;
			res.weekday       <= 3'(jnew_s9 - 23'(24'(wq) * 24'd7));
			res.days_between  <= $signed(diff_s9);
			res.was_defaulted <= dflt_s9;
			res.out_of_range  <= oor_s9;
		end
	end
endmodule

### hw/rtl/gregorian_julian_date_unit_core.sv
// top level of the gregorian date unit
//
// s_* channel: one transaction holds a base date, a signed day offset and a
//   comparison date. a base or comparison date with month above 12 or day
//   above 31 is replaced by 5/11/1959 and was_defaulted is raised.
// m_* channel: one result per input: the shifted date, its julian day number,
//   day of year, weekday (0 monday) and comparison minus shifted day count.
//   if the shifted year leaves 0..9999, out_of_range is set and the base
//   date comes back unshifted.
// throughput: one transaction per cycle while m_tready stays high; the front end (2 stages) feeds a
//   four-entry queue, the back end (10 stages, the last being the output
//   register) drains it, each side pipelined around constant reciprocal
//   multipliers.
// stalls: when m_tvalid is high and m_tready low the back end holds; the queue absorbs up to
//   four more transactions before s_tready drops.
// reset: arst_n clears all valid bits and queue pointers; nothing in flight
//   survives.
module gregorian_julian_date_unit_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// date_month, date_day, date_year, day_offset, other_month, other_day,
	// other_year, zero pad
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// new_month, new_day, new_year, julian_day, day_of_year, weekday,
	// days_between, zero pad
	output logic [87:0] m_tdata,
	// was_defaulted, out_of_range
	output logic [1:0]  m_tuser
);
	gjdu_pkg::in_item_t item;
	gjdu_pkg::q_stat_t  q_stat;
	gjdu_pkg::q_item_t  push_data, head;
	gjdu_pkg::res_t     res;
	logic               push, pop;

	assign item = s_tdata;

	gjdu_front u_front (
		.clk(clk), .arst_n(arst_n), .item(item), .in_valid(s_tvalid),
		.in_ready(s_tready), .q_stat(q_stat), .push(push), .push_data(push_data)
	);

	gjdu_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.pop(pop), .head(head), .stat(q_stat)
	);

	gjdu_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .q_stat(q_stat), .pop(pop),
		.res(res), .res_valid(m_tvalid), .res_ready(m_tready)
	);

	// pack result fields, lowest field first
	assign m_tdata = {7'd0, res.days_between, res.weekday, res.day_of_year,
		res.julian_day, res.new_year, res.new_day, res.new_month};
	assign m_tuser = {res.out_of_range, res.was_defaulted};

	// weekday is a remainder by seven
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res.weekday <= 3'd6)
		else $error("weekday out of range");

	// a shifted date in range is a canonical calendar date
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res.out_of_range |->
			res.new_month >= 4'd1 && res.new_month <= 4'd12 &&
			res.new_day != 5'd0 && res.new_year <= 14'd9999)
		else $error("shifted date not canonical");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res.out_of_range |->
			res.day_of_year != 9'd0 && res.day_of_year <= 9'd366)
		else $error("day of year out of range");

	// the front end only backs up behind a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> q_stat.full)
		else $error("input stalled without full queue");
endmodule

### sim/date_result_checker.sv
// checker for the date unit: predicts each result and compares it on the output channel
`timescale 1ns / 100ps

module date_result_checker (
	input  logic        clk,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [87:0] m_tdata,
	input  logic [1:0]  m_tuser,
	output int          fail_count,
	output int          pending_count
);

	gjdu_pkg::res_t expected_dates[$];
	int             mismatches = 0;

	// fliegel-van flandern day number, truncating division
	function automatic longint day_number(longint m, longint d, longint y);
		longint a;
		a = (m - 14) / 12;
		return d - 32075 + 1461 * (y + 4800 + a) / 4
			+ 367 * (m - 2 - a * 12) / 12
			- 3 * ((y + 4900 + a) / 100) / 4;
	endfunction

	function automatic gjdu_pkg::res_t predict_date(gjdu_pkg::in_item_t it);
		gjdu_pkg::res_t r;
		longint bm, bd, by, om, od, oy, off, jd, l, n, i, j, k, nm, nd, ny, jnew, diff;
		bit     dflt;
		bit     oor;
		bm = it.date_month; bd = it.date_day; by = it.date_year;
		om = it.other_month; od = it.other_day; oy = it.other_year;
		off = longint'($signed(it.day_offset));
		dflt = 0;
		if (bm > 12 || bd > 31) begin
			bm = gjdu_pkg::DEF_MONTH; bd = gjdu_pkg::DEF_DAY; by = gjdu_pkg::DEF_YEAR;
			dflt = 1;
		end
		if (om > 12 || od > 31) begin
			om = gjdu_pkg::DEF_MONTH; od = gjdu_pkg::DEF_DAY; oy = gjdu_pkg::DEF_YEAR;
			dflt = 1;
		end
		jd = day_number(bm, bd, by) + off;
		// back to a calendar date
		l = jd + 68569;
		n = 4 * l / 146097;
		l = l - (146097 * n + 3) / 4;
		i = 4000 * (l + 1) / 1461001;
		l = l - 1461 * i / 4 + 31;
		j = 80 * l / 2447;
		k = l - 2447 * j / 80;
		l = j / 11;
		j = j + 2 - 12 * l;
		i = 100 * (n - 49) + i + l;
		ny = i; nm = j; nd = k;
		oor = 0;
		// shifted year out of range: keep the base date as it is
		if (ny < 0 || ny > 9999) begin
			oor = 1; nm = bm; nd = bd; ny = by;
		end
		jnew = day_number(nm, nd, ny);
		diff = day_number(om, od, oy) - jnew;
		if (diff > 4194303) diff = 4194303;
		if (diff < -4194304) diff = -4194304;
		r.new_month     = nm[3:0];
		r.new_day       = nd[4:0];
		r.new_year      = ny[13:0];
		r.julian_day    = jnew[22:0];
		r.day_of_year   = 9'(jnew - day_number(1, 0, ny));
		r.weekday       = 3'(jnew % 7);
		r.days_between  = diff[22:0];
		r.was_defaulted = dflt;
		r.out_of_range  = oor;
		return r;
	endfunction

	assign fail_count = mismatches;

	always @(posedge clk) begin
		gjdu_pkg::res_t got;
		gjdu_pkg::res_t want;
		if (s_tvalid && s_tready)
			expected_dates.push_back(predict_date(gjdu_pkg::in_item_t'(s_tdata)));
		if (m_tvalid && m_tready) begin
			got.new_month     = m_tdata[3:0];
			got.new_day       = m_tdata[8:4];
			got.new_year      = m_tdata[22:9];
			got.julian_day    = m_tdata[45:23];
			got.day_of_year   = m_tdata[54:46];
			got.weekday       = m_tdata[57:55];
			got.days_between  = m_tdata[80:58];
			got.was_defaulted = m_tuser[0];
			got.out_of_range  = m_tuser[1];
			if (expected_dates.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: %p", got);
			end else begin
				want = expected_dates.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch\n  expected %p\n  actual   %p", want, got);
				end
			end
		end
		pending_count = expected_dates.size();
	end

endmodule

### sim/tb_gregorian_julian_date_unit_core.sv
// testbench top for the date unit: stimulus, stalls and verdict
`timescale 1ns / 100ps

module tb_gregorian_julian_date_unit_core;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 40;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;
	logic [1:0]  m_tuser;
	int          fail_count;
	int          pending_count;

	// idle percentages for the current phase
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles = 0;

	gregorian_julian_date_unit_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	date_result_checker checker_i (
		.clk           (clk),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// receiver side: random stall decided at each falling edge
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog on cycles where neither channel moves a transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic gjdu_pkg::in_item_t make_item(int bm, int bd, int by, int off,
		int om, int od, int oy);
		gjdu_pkg::in_item_t it;
		it = '0;
		it.date_month  = 4'(bm);
		it.date_day    = 6'(bd);
		it.date_year   = 14'(by);
		it.day_offset  = 21'(off);
		it.other_month = 4'(om);
		it.other_day   = 6'(od);
		it.other_year  = 14'(oy);
		return it;
	endfunction

	// mostly valid dates; half the offsets are modest, the rest full-width,
	// with some defaulted dates and overlong years mixed in
	function automatic gjdu_pkg::in_item_t random_item();
		gjdu_pkg::in_item_t it;
		int                 pick;
		it = gjdu_pkg::in_item_t'(72'({$urandom, $urandom, $urandom}));
		it.pad = '0;
		if ($urandom_range(9) < 8) begin
			it.date_month  = 4'($urandom_range(12, 1));
			it.date_day    = 6'($urandom_range(31, 1));
			it.other_month = 4'($urandom_range(12, 1));
			it.other_day   = 6'($urandom_range(31, 1));
		end
		if ($urandom_range(9) < 9) begin
			it.date_year  = 14'($urandom_range(9999));
			it.other_year = 14'($urandom_range(9999));
		end
		pick = $urandom_range(3);
		case (pick)
			0:       it.day_offset = 21'($signed($urandom_range(2000)) - 1000);
			1:       it.day_offset = 21'($signed($urandom_range(200000)) - 100000);
			default: it.day_offset = 21'($urandom);
		endcase
		return it;
	endfunction

	task automatic send_item(gjdu_pkg::in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= it;
		forever begin
			@(posedge clk);
			if (s_tready) break;
		end
	endtask

	task automatic finish_sending();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, leap days, defaulting and range exits
		send_item(make_item(1, 1, 2000, 0, 1, 1, 2000));
		send_item(make_item(12, 31, 9999, 1, 1, 1, 0));          // past the last year
		send_item(make_item(1, 1, 0, -1, 12, 31, 9999));         // before year zero
		send_item(make_item(1, 1, 0, 1048575, 6, 15, 5000));     // largest offset
		send_item(make_item(12, 31, 9999, -1048576, 3, 1, 100)); // smallest offset
		send_item(make_item(13, 5, 2020, 10, 2, 2, 2002));       // month too big
		send_item(make_item(4, 32, 2020, 10, 2, 2, 2002));       // day too big
		send_item(make_item(15, 63, 16383, 0, 15, 63, 16383));   // both defaulted
		send_item(make_item(2, 3, 2021, 5, 0, 40, 1999));        // other defaulted
		send_item(make_item(0, 0, 2000, 0, 0, 0, 0));            // month and day zero
		send_item(make_item(0, 0, 9999, 1048575, 1, 1, 1));      // odd date kept unshifted
		send_item(make_item(2, 29, 2000, 365, 2, 28, 1900));     // leap day
		send_item(make_item(2, 28, 1900, 1, 3, 1, 1900));        // century non-leap
		send_item(make_item(12, 31, 2004, 0, 1, 1, 2005));       // day 366
		send_item(make_item(1, 1, 0, 0, 12, 31, 16383));         // difference saturates high
		send_item(make_item(6, 6, 16383, 0, 1, 1, 0));           // high year, low side
		send_item(make_item(7, 4, 16383, 1048575, 1, 1, 0));     // overlong year shifted
		send_item(make_item(10, 15, 1582, -7, 10, 4, 1582));
		send_item(make_item(5, 11, 1959, 0, 5, 11, 1959));

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1:       begin send_idle_pct = 53; recv_stall_pct = 0;  end
				2:       begin send_idle_pct = 0;  recv_stall_pct = 53; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			for (int n = 0; n < 208; n++)
				send_item(random_item());
		end
		finish_sending();

		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
